### design/crt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_pkg
// Types and codes shared by the CAN identifier rule table modules.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int IdW   = 29;
  localparam int RateW = 16;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_UPSERT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [IdW-1:0]   can_id;
    logic             ignore_flag;
    logic [RateW-1:0] rate_limit;
    logic [5:0]       entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [IdW-1:0]   rule_id;
    logic             rule_ignored;
    logic [RateW-1:0] rule_rate;
    logic [6:0]       rule_count;
  } out_item_t;

  // One stored rule as it sits in the table memory.
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic             ignored;
    logic [RateW-1:0] rate;
  } rule_t;

endpackage
`default_nettype wire

### design/crt_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_mem
// Rule storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crt_mem
  import crt_pkg::*;
#(
  parameter int MAX_RULES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MAX_RULES)-1:0] rd_addr,
  output rule_t                             rd_data,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_RULES)-1:0] wr_addr,
  input  wire rule_t                        wr_data
);

  rule_t mem [MAX_RULES];
  rule_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### design/crt_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_seq
// Sequencer: walks the sorted table with one identifier comparator and, for an
// insert or delete, shifts entries one per cycle to open or close a gap.
// ----------------------------------------------------------------------------
module crt_seq
  import crt_pkg::*;
#(
  parameter int MAX_RULES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire in_item_t                     in_item,
  output logic                              out_valid,
  output out_item_t                         out_item,
  output logic                              rd_en,
  output logic [$clog2(MAX_RULES)-1:0]      rd_addr,
  input  wire rule_t                        rd_data,
  output logic                              wr_en,
  output logic [$clog2(MAX_RULES)-1:0]      wr_addr,
  output rule_t                             wr_data
);

  localparam int AW = $clog2(MAX_RULES);
  localparam int CW = $clog2(MAX_RULES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_SHDN  = 3'd3;
  localparam logic [2:0] S_SHUP  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_RDRES = 3'd6;

  logic [2:0]    state_r, state_nxt;
  in_item_t      req_r, req_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_idx_r, pend_idx_nxt;
  logic          hit_r, hit_nxt;
  rule_t         hit_rule_r, hit_rule_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic [CW-1:0] idx_inc, idx_dec, count_inc, count_dec;
  logic          del_req, table_full, read_ok;
  rule_t         new_rule;

  function automatic out_item_t mk_res(input logic [1:0] st, input logic fnd,
                                       input rule_t rule, input logic [CW-1:0] cnt);
    out_item_t r;
    r.status       = st;
    r.found        = fnd;
    r.rule_id      = fnd ? rule.id : '0;
    r.rule_ignored = fnd ? rule.ignored : 1'b0;
    r.rule_rate    = fnd ? rule.rate : '0;
    r.rule_count   = 7'(cnt);
    return r;
  endfunction

  assign idx_inc    = idx_r + CW'(1);
  assign idx_dec    = idx_r - CW'(1);
  assign count_inc  = count_r + CW'(1);
  assign count_dec  = count_r - CW'(1);
  assign del_req    = !req_r.ignore_flag && (req_r.rate_limit == '0);
  assign table_full = (count_r == CW'(MAX_RULES));
  assign read_ok    = 32'(req_r.entry_index) < 32'(count_r);
  assign new_rule   = '{id: req_r.can_id, ignored: req_r.ignore_flag,
                        rate: req_r.rate_limit};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    hit_nxt       = hit_r;
    hit_rule_nxt  = hit_rule_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = pend_idx_r[AW-1:0];
    wr_data       = rd_data;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = in_item;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          if (in_item.command == CMD_LOOKUP || in_item.command == CMD_UPSERT) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      // Reads run one entry ahead of the comparator; the scan stops at the
      // first identifier that is not below the requested one.
      S_SCAN: begin
        if (pend_r && (rd_data.id >= req_r.can_id)) begin
          hit_nxt      = (rd_data.id == req_r.can_id);
          hit_rule_nxt = rd_data;
          pos_nxt      = pend_idx_r;
          pend_nxt     = 1'b0;
          state_nxt    = S_ACT;
        end else if (idx_r < count_r) begin
          rd_en        = 1'b1;
          rd_addr      = idx_r[AW-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_inc;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            hit_nxt   = 1'b0;
            pos_nxt   = count_r;
            state_nxt = S_ACT;
          end
        end
      end

      S_ACT: begin
        state_nxt = S_IDLE;
        case (req_r.command)
          CMD_LOOKUP: begin
            out_valid_nxt = 1'b1;
            out_nxt = mk_res(hit_r ? ST_OK : ST_MISS, hit_r, hit_rule_r, count_r);
          end
          CMD_UPSERT: begin
            if (del_req) begin
              if (hit_r) begin
                idx_nxt   = pos_r + CW'(1);
                pend_nxt  = 1'b0;
                state_nxt = S_SHDN;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt = mk_res(ST_OK, 1'b0, new_rule, count_r);
              end
            end else if (hit_r) begin
              wr_en         = 1'b1;
              wr_addr       = pos_r[AW-1:0];
              wr_data       = new_rule;
              out_valid_nxt = 1'b1;
              out_nxt       = mk_res(ST_OK, 1'b1, new_rule, count_r);
            end else if (table_full) begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk_res(ST_FULL, 1'b0, new_rule, count_r);
            end else begin
              idx_nxt   = count_r;
              pend_nxt  = 1'b0;
              state_nxt = S_SHUP;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_nxt = mk_res(ST_MISS, 1'b0, new_rule, count_r);
          end
        endcase
      end

      // Close the gap: entry j moves to j-1, one entry per cycle.
      S_SHDN: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx_r[AW-1:0];
          wr_data = rd_data;
        end
        if (idx_r < count_r) begin
          rd_en        = 1'b1;
          rd_addr      = idx_r[AW-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_dec;
          idx_nxt      = idx_inc;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt     = count_dec;
            out_valid_nxt = 1'b1;
            out_nxt       = mk_res(ST_OK, 1'b0, new_rule, count_dec);
            state_nxt     = S_IDLE;
          end
        end
      end

      // Open a gap: entry j-1 moves to j from the top down, then the new
      // rule lands in the freed slot.
      S_SHUP: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx_r[AW-1:0];
          wr_data = rd_data;
        end
        if (idx_r > pos_r) begin
          rd_en        = 1'b1;
          rd_addr      = idx_dec[AW-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_dec;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            wr_en         = 1'b1;
            wr_addr       = pos_r[AW-1:0];
            wr_data       = new_rule;
            count_nxt     = count_inc;
            out_valid_nxt = 1'b1;
            out_nxt       = mk_res(ST_OK, 1'b1, new_rule, count_inc);
            state_nxt     = S_IDLE;
          end
        end
      end

      S_READ: begin
        if (req_r.command == CMD_READ && read_ok) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(req_r.entry_index);
          state_nxt = S_RDRES;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_res(ST_MISS, 1'b0, new_rule, count_r);
          state_nxt     = S_IDLE;
        end
      end

      S_RDRES: begin
        out_valid_nxt = 1'b1;
        out_nxt       = mk_res(ST_OK, 1'b1, rd_data, count_r);
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_r      <= hit_nxt;
    hit_rule_r <= hit_rule_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

### design/can_id_rule_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_id_rule_table
// Table of CAN filter rules sorted by identifier, with lookup, upsert or
// delete, and read by position.
// ----------------------------------------------------------------------------
// Usage: drive in_item and raise start while busy is low; the item is taken
// at that clock edge and busy stays high until the item is finished.
// Exactly one result per item appears on out_item for a single cycle,
// marked by out_valid; the receiver cannot hold it off, so it must take
// the result in that cycle.
// A lookup or upsert walks the table from the bottom with a single
// identifier comparator at one entry per cycle (reads are pipelined one
// entry ahead), then an insert or delete moves the later entries one per
// cycle through the single write port of the rule memory, so the walk and
// the shift together read each stored rule once (an insert reads the entry
// at its slot twice). An unused command finishes soonest, a read by position
// passes through one more state, and the longest items are an insert into a
// table one short of full and a delete from a full table.
// The next item can be started in the cycle in which the result is shown.
// Reset clears the rule count, so the table starts empty; the rule memory
// itself is not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module can_id_rule_table
  import crt_pkg::*;
#(
  parameter int MAX_RULES = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);

  localparam int AW = $clog2(MAX_RULES);

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  rule_t         rd_data, wr_data;

  crt_seq #(
    .MAX_RULES (MAX_RULES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  crt_mem #(
    .MAX_RULES (MAX_RULES)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule
`default_nettype wire

### design/crt_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crt_chk
// Port-level checks for the rule table, bound to the top level.
// ----------------------------------------------------------------------------
module crt_chk
  import crt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_item
);

  // Every item passes a busy state, so results never come back to back.
  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.found) |-> (out_item.status == ST_OK))
    else $error("rule returned with a non-ok status");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |->
      (out_item.rule_id == '0 && !out_item.rule_ignored && out_item.rule_rate == '0))
    else $error("rule fields not cleared without a rule");

endmodule

bind can_id_rule_table crt_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

### test/can_id_rule_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_id_rule_table_tb
// Drives lookup, upsert, delete and read-by-position items into the rule
// table and checks every result against a sorted-table predictor kept here.
// A directed opening covers the empty table, both identifier extremes,
// in-place updates and deletes at either end. Random rounds then grow, mix
// and drain the table so that it often fills up and inserts report full.
// ----------------------------------------------------------------------------
module can_id_rule_table_tb;
  import crt_pkg::*;

  localparam int MaxRules = 64;
  localparam int RandItems = 1600;
  localparam int RoundLen = 200;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 2 * MaxRules + 10;
  localparam int PoolSize = 96;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [IdW-1:0] IdMax = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;

  // Predicted table contents.
  logic [IdW-1:0] rule_ids [0:MaxRules-1];
  logic rule_ign [0:MaxRules-1];
  logic [RateW-1:0] rule_rates [0:MaxRules-1];
  int rule_total = 0;

  in_item_t items_waiting[$];
  out_item_t results_due[$];
  int items_total = 0;
  int items_taken = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int gap_left = 0;
  logic took = 1'b0;

  can_id_rule_table #(.MAX_RULES(MaxRules)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic in_item_t mk(logic [1:0] c, logic [IdW-1:0] id, logic ign,
                                  logic [RateW-1:0] rate, logic [5:0] idx);
    in_item_t it;
    it.command = c;
    it.can_id = id;
    it.ignore_flag = ign;
    it.rate_limit = rate;
    it.entry_index = idx;
    return it;
  endfunction

  // First position whose identifier is not below id.
  function automatic int first_not_below(logic [IdW-1:0] id);
    int p;
    p = 0;
    while (p < rule_total && rule_ids[p] < id) p++;
    return p;
  endfunction

  // Applies one item to the predicted table and returns the result it gives.
  function automatic out_item_t apply_rule_item(in_item_t it);
    out_item_t r;
    int pos;
    int k;
    bit present;
    bit hit;
    r = '0;
    r.status = ST_MISS;
    hit = 1'b0;
    pos = first_not_below(it.can_id);
    present = (pos < rule_total) && (rule_ids[pos] == it.can_id);
    case (it.command)
      CMD_LOOKUP: begin
        if (present) begin
          hit = 1'b1;
          r.status = ST_OK;
        end
      end
      CMD_UPSERT: begin
        if (!it.ignore_flag && it.rate_limit == '0) begin
          if (present) begin
            for (k = pos; k + 1 < rule_total; k++) begin
              rule_ids[k] = rule_ids[k+1];
              rule_ign[k] = rule_ign[k+1];
              rule_rates[k] = rule_rates[k+1];
            end
            rule_total--;
          end
          r.status = ST_OK;
        end else if (!present && rule_total >= MaxRules) begin
          r.status = ST_FULL;
        end else begin
          if (!present) begin
            for (k = rule_total; k > pos; k--) begin
              rule_ids[k] = rule_ids[k-1];
              rule_ign[k] = rule_ign[k-1];
              rule_rates[k] = rule_rates[k-1];
            end
            rule_ids[pos] = it.can_id;
            rule_total++;
          end
          rule_ign[pos] = it.ignore_flag;
          rule_rates[pos] = it.rate_limit;
          hit = 1'b1;
          r.status = ST_OK;
        end
      end
      CMD_READ: begin
        if (int'(it.entry_index) < rule_total) begin
          pos = int'(it.entry_index);
          hit = 1'b1;
          r.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    if (hit) begin
      r.found = 1'b1;
      r.rule_id = rule_ids[pos];
      r.rule_ignored = rule_ign[pos];
      r.rule_rate = rule_rates[pos];
    end
    r.rule_count = rule_total[6:0];
    return r;
  endfunction

  // Driver: a raised start is held until the item is taken.
  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      // Idling comes in bursts, only in some stretches, and never near the end.
      if (gap_left == 0 && items_waiting.size() > 300 &&
          (items_waiting.size() / 100) % 3 != 0 && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 15);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (items_waiting.size() != 0) begin
        in_item <= items_waiting.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor and predictor. The older expectation is consumed before the item
  // taken at the same edge adds its own.
  always @(posedge clk) begin
    out_item_t want;
    took <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: st=%0d f=%0d id=%h ign=%0d rate=%0d cnt=%0d",
                   out_item.status, out_item.found, out_item.rule_id,
                   out_item.rule_ignored, out_item.rule_rate, out_item.rule_count);
        end
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_item.status !== want.status || out_item.found !== want.found ||
            out_item.rule_id !== want.rule_id ||
            out_item.rule_ignored !== want.rule_ignored ||
            out_item.rule_rate !== want.rule_rate ||
            out_item.rule_count !== want.rule_count) begin
          if (mismatches < 10) begin
            $display("mismatch exp: st=%0d f=%0d id=%h ign=%0d rate=%0d cnt=%0d",
                     want.status, want.found, want.rule_id, want.rule_ignored,
                     want.rule_rate, want.rule_count);
            $display("         got: st=%0d f=%0d id=%h ign=%0d rate=%0d cnt=%0d",
                     out_item.status, out_item.found, out_item.rule_id,
                     out_item.rule_ignored, out_item.rule_rate, out_item.rule_count);
          end
          mismatches++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      results_due.push_back(apply_rule_item(in_item));
      items_taken++;
    end
  end

  // Watchdog on cycles in which no item is taken.
  always @(posedge clk) begin
    if (!rst_n || took) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [IdW-1:0] id_pool [0:PoolSize-1];
    logic [IdW-1:0] rid;
    int ins_cut [0:2];
    int del_cut [0:2];
    int look_cut [0:2];
    in_item_t it;
    int n;
    int mode;
    int pick;

    // Directed opening on an empty table, then both identifier extremes.
    items_waiting.push_back(mk(CMD_LOOKUP, '0, $urandom, $urandom, $urandom));
    items_waiting.push_back(mk(CMD_READ, $urandom, $urandom, $urandom, 6'd0));
    items_waiting.push_back(mk(CMD_UPSERT, 29'd5, 1'b0, 16'd0, $urandom));
    items_waiting.push_back(mk(CMD_UPSERT, IdMax, 1'b1, 16'hFFFF, $urandom));
    items_waiting.push_back(mk(CMD_UPSERT, '0, 1'b0, 16'd1, $urandom));
    // An ignored rule with no rate limit is stored, not deleted.
    items_waiting.push_back(mk(CMD_UPSERT, 29'h0ABCDEF, 1'b1, 16'd0, $urandom));
    items_waiting.push_back(mk(CMD_UPSERT, 29'h0ABCDEE, 1'b0, 16'h8000, $urandom));
    items_waiting.push_back(mk(CMD_UPSERT, '0, 1'b1, 16'hFFFF, $urandom));
    items_waiting.push_back(mk(CMD_LOOKUP, IdMax, $urandom, $urandom, $urandom));
    items_waiting.push_back(mk(CMD_LOOKUP, 29'h0ABCDF0, $urandom, $urandom, $urandom));
    for (n = 0; n < 5; n++) begin
      items_waiting.push_back(mk(CMD_READ, $urandom, $urandom, $urandom, n[5:0]));
    end
    items_waiting.push_back(mk(CMD_READ, $urandom, $urandom, $urandom, 6'd63));
    items_waiting.push_back(mk(CmdUnused, $urandom, $urandom, $urandom, $urandom));
    items_waiting.push_back(mk(CMD_UPSERT, 29'h0ABCDEE, 1'b0, 16'd0, $urandom));
    items_waiting.push_back(mk(CMD_UPSERT, 29'h1234, 1'b0, 16'd0, $urandom));
    items_waiting.push_back(mk(CMD_UPSERT, IdMax, 1'b0, 16'd0, $urandom));
    items_waiting.push_back(mk(CMD_LOOKUP, IdMax, $urandom, $urandom, $urandom));
    items_waiting.push_back(mk(CMD_UPSERT, '0, 1'b0, 16'd0, $urandom));
    items_waiting.push_back(mk(CMD_READ, $urandom, $urandom, $urandom, 6'd0));

    // A pool a bit larger than the table, so that grow rounds fill it up
    // while lookups and deletes still hit stored rules.
    for (n = 0; n < PoolSize; n++) id_pool[n] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = IdMax;
    id_pool[3] = id_pool[2] + 1'b1;

    // Rounds cycle through grow, mixed and drain mixes of commands.
    ins_cut = '{60, 35, 15};
    del_cut = '{68, 55, 65};
    look_cut = '{82, 75, 80};
    for (n = 0; n < RandItems; n++) begin
      mode = (n / RoundLen) % 3;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) rid = $urandom;
      else rid = id_pool[$urandom_range(0, PoolSize - 1)];
      it = mk($urandom, rid, $urandom, $urandom, $urandom);
      if (pick < ins_cut[mode]) begin
        it.command = CMD_UPSERT;
        if (it.rate_limit == '0) it.ignore_flag = 1'b1;
      end else if (pick < del_cut[mode]) begin
        it.command = CMD_UPSERT;
        it.ignore_flag = 1'b0;
        it.rate_limit = '0;
      end else if (pick < look_cut[mode]) begin
        it.command = CMD_LOOKUP;
      end else if (pick < 95) begin
        it.command = CMD_READ;
      end
      items_waiting.push_back(it);
    end
    items_total = items_waiting.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_taken < items_total) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    // Leave room for any stray result before the verdict.
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
design/crt_pkg.sv
design/crt_mem.sv
design/crt_seq.sv
design/can_id_rule_table.sv
design/crt_chk.sv
test/can_id_rule_table_tb.sv
